// File: rtl/assert_macros.svh
// Assertion macros used by the converter top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/i2f_pkg.sv
// ----------------------------------------------------------------------------
// i2f_pkg
// Types and constants shared by the integer/float converter modules.
// ----------------------------------------------------------------------------
`default_nettype none
package i2f_pkg;
    localparam logic [31:0] INT_MOST_NEG = 32'h8000_0000;
    localparam logic [31:0] INT_MOST_POS = 32'h7FFF_FFFF;
    localparam logic [0:0]  DIR_I2F = 1'b0;
    localparam logic [0:0]  DIR_F2I = 1'b1;
    localparam logic [0:0]  ADDR_DIRECTION = 1'b0;

    // Side information that travels with a word through the pipeline.
    typedef struct packed {
        logic dir;
        logic last;
    } side_t;
endpackage
`default_nettype wire

// File: rtl/i2f_norm.sv
// ----------------------------------------------------------------------------
// i2f_norm
// Stages 1 and 2: sign/magnitude split, leading-one search and normalize.
// ----------------------------------------------------------------------------
`default_nettype none
module i2f_norm
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                valid_in,
    input  wire logic [31:0]         word,
    input  wire i2f_pkg::side_t      side_in,
    output logic                     valid_out,
    output i2f_pkg::side_t           side_out,
    output logic [31:0]              word_q,
    output logic [31:0]              norm_q,
    output logic [4:0]               lead_q,
    output logic                     zero_q
);
    import i2f_pkg::*;

    logic          v1_reg;
    side_t         s1_reg;
    logic [31:0]   w1_reg;
    logic [31:0]   mag1_reg;
    logic [31:0]   mag_next;
    logic [4:0]    p_next;
    logic          v2_reg;
    side_t         s2_reg;
    logic [31:0]   w2_reg;
    logic [31:0]   n2_reg;
    logic [4:0]    p2_reg;
    logic          z2_reg;

    // Integer magnitude; for float mode the field is unused.
    assign mag_next = word[31] ? (32'd0 - word) : word;

    // Leading-one position of the stage 1 magnitude.
    always_comb
    begin
        p_next = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (mag1_reg[i])
            begin
                p_next = 5'(i);
            end
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg   <= side_in;
            w1_reg   <= word;
            mag1_reg <= mag_next;
            s2_reg   <= s1_reg;
            w2_reg   <= w1_reg;
            p2_reg   <= p_next;
            n2_reg   <= mag1_reg << (5'd31 - p_next);
            z2_reg   <= (mag1_reg == 32'd0);
        end
    end

    assign valid_out = v2_reg;
    assign side_out  = s2_reg;
    assign word_q    = w2_reg;
    assign norm_q    = n2_reg;
    assign lead_q    = p2_reg;
    assign zero_q    = z2_reg;
endmodule
`default_nettype wire

// File: rtl/i2f_pack.sv
// ----------------------------------------------------------------------------
// i2f_pack
// Stages 3 and 4: rounding and float packing, or float-to-integer shift.
// ----------------------------------------------------------------------------
`default_nettype none
module i2f_pack
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                valid_in,
    input  wire i2f_pkg::side_t      side_in,
    input  wire logic [31:0]         word,
    input  wire logic [31:0]         norm,
    input  wire logic [4:0]          lead,
    input  wire logic                zero,
    output logic                     valid_out,
    output logic                     last_q,
    output logic [31:0]              result_q,
    output logic                     inexact_q,
    output logic                     invalid_q
);
    import i2f_pkg::*;

    logic          v3_reg;
    side_t         s3_reg;
    logic [31:0]   res3_reg;
    logic          inx3_reg;
    logic          inv3_reg;
    logic [24:0]   q3_reg;
    logic [7:0]    ex3_reg;
    logic          sg3_reg;
    logic          v4_reg;
    logic          l4_reg;
    logic [31:0]   r4_reg;
    logic          inx4_reg;
    logic          inv4_reg;

    // Float to integer path.
    logic [7:0]    fe;
    logic [22:0]   ff;
    logic [31:0]   fmag;
    logic [31:0]   f_res;
    logic          f_inv;
    // Integer to float rounding.
    logic [23:0]   keep;
    logic          rbit;
    logic          sticky;
    logic          up;
    logic [24:0]   q_next;

    always_comb
    begin
        fe   = word[30:23];
        ff   = word[22:0];
        fmag = 32'd0;
        f_res = 32'd0;
        f_inv = 1'b0;
        if (fe == 8'hFF && ff != 23'd0)
        begin
            f_res = INT_MOST_NEG;
            f_inv = 1'b1;
        end
        else if (fe < 8'd127)
        begin
            f_res = 32'd0;
        end
        else if (fe >= 8'd158)
        begin
            if (word[31] && fe == 8'd158 && ff == 23'd0)
            begin
                f_res = INT_MOST_NEG;
            end
            else
            begin
                f_inv = 1'b1;
                f_res = word[31] ? INT_MOST_NEG : INT_MOST_POS;
            end
        end
        else
        begin
            fmag  = {1'b1, ff, 8'd0} >> (8'd158 - fe);
            f_res = word[31] ? (32'd0 - fmag) : fmag;
        end
    end

    // Round to nearest even on the normalized magnitude.
    always_comb
    begin
        keep   = norm[31:8];
        rbit   = norm[7];
        sticky = (norm[6:0] != 7'd0);
        up     = rbit && (sticky || keep[0]);
        q_next = {1'b0, keep} + {24'd0, up};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= valid_in;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg   <= side_in;
            res3_reg <= f_res;
            inv3_reg <= f_inv;
            inx3_reg <= (rbit || sticky) && !zero;
            q3_reg   <= q_next;
            ex3_reg  <= 8'd127 + {3'd0, lead};
            sg3_reg  <= word[31];
            l4_reg   <= s3_reg.last;
            if (s3_reg.dir == DIR_F2I)
            begin
                r4_reg   <= res3_reg;
                inv4_reg <= inv3_reg;
                inx4_reg <= 1'b0;
            end
            else
            begin
                inv4_reg <= 1'b0;
                inx4_reg <= inx3_reg;
                if (ex3_reg == 8'd127 && q3_reg == 25'd0)
                begin
                    r4_reg <= 32'd0;
                end
                else if (q3_reg[24])
                begin
                    r4_reg <= {sg3_reg, ex3_reg + 8'd1, q3_reg[23:1]};
                end
                else
                begin
                    r4_reg <= {sg3_reg, ex3_reg, q3_reg[22:0]};
                end
            end
        end
    end

    assign valid_out = v4_reg;
    assign last_q    = l4_reg;
    assign result_q  = r4_reg;
    assign inexact_q = inx4_reg;
    assign invalid_q = inv4_reg;
endmodule
`default_nettype wire

// File: rtl/int32_float32_converter.sv
// ----------------------------------------------------------------------------
// int32_float32_converter
// Streaming converter between int32 and IEEE-754 single-precision words.
// ----------------------------------------------------------------------------
// Input beats arrive on s_axis (tdata = word_in, tlast = last_in) and results
// leave on m_axis: tdata[31:0] = word_out, tuser[0] = inexact,
// tuser[1] = invalid, tlast = last_out.
// The APB register at address 0 selects the direction: 0 integer to float,
// 1 float to integer. Write it only while the pipeline is empty.
// Throughput is one beat per cycle while m_axis is not stalled; the pipeline has
// four stages (split, normalize, round, pack).
// The whole pipeline advances when the output register is empty or being
// taken, so a stall on m_axis holds every stage and loses no beat.
// Reset clears all valid bits and sets the direction to integer to float.
// ----------------------------------------------------------------------------
`default_nettype none
module int32_float32_converter
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [31:0]   s_axis_tdata,   // word_in
    input  wire logic          s_axis_tlast,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [31:0]        m_axis_tdata,   // word_out
    output logic [1:0]         m_axis_tuser,   // bit 1 invalid, bit 0 inexact
    output logic               m_axis_tlast,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [0:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import i2f_pkg::*;
`include "assert_macros.svh"

    logic          dir_reg;
    logic          en;
    side_t         side;
    logic          v2;
    side_t         s2;
    logic [31:0]   w2;
    logic [31:0]   n2;
    logic [4:0]    p2;
    logic          z2;
    logic          inx;
    logic          inv;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_DIRECTION) ? {31'd0, dir_reg} : 32'd0;

    // Direction register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= DIR_I2F;
        end
        else if (psel && penable && pwrite && paddr == ADDR_DIRECTION)
        begin
            dir_reg <= pwdata[0];
        end
    end

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign side.dir      = dir_reg;
    assign side.last     = s_axis_tlast;

    i2f_norm u_norm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (s_axis_tvalid),
        .word      (s_axis_tdata),
        .side_in   (side),
        .valid_out (v2),
        .side_out  (s2),
        .word_q    (w2),
        .norm_q    (n2),
        .lead_q    (p2),
        .zero_q    (z2)
    );

    i2f_pack u_pack
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (v2),
        .side_in   (s2),
        .word      (w2),
        .norm      (n2),
        .lead      (p2),
        .zero      (z2),
        .valid_out (m_axis_tvalid),
        .last_q    (m_axis_tlast),
        .result_q  (m_axis_tdata),
        .inexact_q (inx),
        .invalid_q (inv)
    );

    assign m_axis_tuser = {inv, inx};

    `ASSERT_IMPL(a_flags_excl, clk, rst_n, m_axis_tvalid, !(inx && inv), "both flags set")
    `ASSERT_IMPL(a_ready_stall, clk, rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready,
        "input taken during stall")
    `ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule
`default_nettype wire

// File: bench/int32_float32_converter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// int32_float32_converter_test
// Self-checking bench for the int32/float32 stream converter. A predictor
// built from integer bit fields computes each converted word and its flags.
// A scoreboard compares every output beat in order. The run covers both
// directions, directed corner values, random words and several idle patterns
// on both stream sides.
// ----------------------------------------------------------------------------
module int32_float32_converter_test;
    import i2f_pkg::*;

    // One converted word with its flags, as it leaves the block.
    typedef struct packed {
        logic [31:0] word;
        logic        inexact;
        logic        invalid;
        logic        last;
    } conv_t;

    // Scoreboard: predicts conversions and holds them until they come out.
    class conv_scoreboard;
        conv_t       pending[$];
        logic        dir;
        int unsigned mismatches;
        int unsigned stray;

        function new();
            dir = DIR_I2F;
            mismatches = 0;
            stray = 0;
        endfunction

        // Integer to float, rounding to nearest even.
        function conv_t to_float(logic [31:0] w);
            conv_t       r;
            logic [31:0] mag;
            logic [31:0] rem;
            logic [31:0] half;
            logic [31:0] q;
            logic [7:0]  ex;
            int          p;
            int          sh;
            r = '0;
            mag = w[31] ? (32'd0 - w) : w;
            if (mag == 0)
                return r;
            p = 31;
            while (!mag[p])
                p--;
            ex = 8'(127 + p);
            if (p <= 23)
            begin
                q = mag << (23 - p);
            end
            else
            begin
                sh = p - 23;
                rem = mag & ((32'd1 << sh) - 1);
                half = 32'd1 << (sh - 1);
                q = mag >> sh;
                if (rem > half || (rem == half && q[0]))
                    q++;
                if (q == (32'd1 << 24))
                begin
                    q = q >> 1;
                    ex++;
                end
                r.inexact = (rem != 0);
            end
            r.word = {w[31], ex, q[22:0]};
            return r;
        endfunction

        // Float to integer, truncating toward zero with saturation.
        function conv_t to_int(logic [31:0] w);
            conv_t       r;
            logic [7:0]  e;
            logic [22:0] frac;
            logic [31:0] mag;
            int          k;
            r = '0;
            e = w[30:23];
            frac = w[22:0];
            if (e == 8'hFF && frac != 0)
            begin
                r.invalid = 1'b1;
                r.word = INT_MOST_NEG;
                return r;
            end
            if (e < 127)
                return r;
            k = int'(e) - 127;
            if (k >= 31)
            begin
                if (w[31] && e == 8'd158 && frac == 0)
                begin
                    r.word = INT_MOST_NEG;
                    return r;
                end
                r.invalid = 1'b1;
                r.word = w[31] ? INT_MOST_NEG : INT_MOST_POS;
                return r;
            end
            mag = {9'd1, frac};
            mag = (k <= 23) ? (mag >> (23 - k)) : (mag << (k - 23));
            r.word = w[31] ? (32'd0 - mag) : mag;
            return r;
        endfunction

        function void note_input(logic [31:0] w, logic last);
            conv_t r;
            r = (dir == DIR_I2F) ? to_float(w) : to_int(w);
            r.last = last;
            pending.push_back(r);
        endfunction

        function void check_output(conv_t got);
            conv_t want;
            if (pending.size() == 0)
            begin
                stray++;
                if (mismatches + stray <= 10)
                    $display("Unexpected output beat %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches + stray <= 10)
                    $display("Mismatch: expected word %h inx %b inv %b last %b, got %h %b %b %b",
                             want.word, want.inexact, want.invalid, want.last,
                             got.word, got.inexact, got.invalid, got.last);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    conv_scoreboard board = new();
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 1'b0;
    int unsigned hold_cycles = 0;
    int unsigned cycle_count = 0;

    int32_float32_converter DUT (.*);

    always #5 clk = ~clk;

    // Cycle limit for a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_output({m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1],
                                m_axis_tlast});
        if (hold_off)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 60)
                hold_off <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one beat, waiting for acceptance; random idle cycles first.
    task automatic send_word(logic [31:0] w, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_input(w, last);
    endtask

    // Wait until every beat is out, then let the pipeline settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_direction(logic d);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_DIRECTION;
        pwdata <= {31'd0, d};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.dir = d;
        @(posedge clk);
    endtask

    // Random word biased toward interesting float and integer shapes.
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(7))
            0: w[30:23] = 8'(127 + $urandom_range(35));
            1: w[30:23] = 8'hFF;
            2: w[30:23] = 8'(120 + $urandom_range(10));
            3: w = w >> $urandom_range(31);
            4: w = -(w >> $urandom_range(31));
            default: ;
        endcase
        return w;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            send_word(pick_word(), ($urandom_range(7) == 0));
    endtask

    logic [31:0] corners_i2f[12] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h00FF_FFFF, 32'h0100_0001, 32'h0100_0003, 32'h0200_0002,
        32'h0300_0004, 32'hFEFF_FFFF, 32'h1234_5678};
    logic [31:0] corners_f2i[13] = '{32'h0, 32'h8000_0000, 32'h0000_0001, 32'h3F7F_FFFF,
        32'h3F80_0000, 32'hBFC0_0000, 32'hCF00_0000, 32'hCF00_0001, 32'h4F00_0000,
        32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001, 32'h4EFF_FFFF};

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners in both directions.
        write_direction(DIR_I2F);
        foreach (corners_i2f[i])
            send_word(corners_i2f[i], i[0]);
        drain();
        write_direction(DIR_F2I);
        foreach (corners_f2i[i])
            send_word(corners_f2i[i], i[0]);
        drain();

        // Random phases with each idle pattern, alternating direction.
        for (int ph = 0; ph < 8; ph++)
        begin
            write_direction(ph[0]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            if (ph == 2)
            begin
                hold_cycles = 0;
                hold_off = 1'b1;
            end
            random_phase(185);
            drain();
        end

        if (board.mismatches == 0 && board.stray == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
